FILE: hdl/two_wire_jtag_shift_sequencer_macros.svh
// Assertion macros for the two-wire JTAG shift sequencer.
// Used by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef TWO_WIRE_JTAG_SHIFT_SEQUENCER_MACROS_SVH
`define TWO_WIRE_JTAG_SHIFT_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TJSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tjss: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define TJSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tjss: next-cycle check failed");

`endif

FILE: hdl/tjss_pkg.sv
// Shared types and constants for the two-wire JTAG shift sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tjss_pkg;

    // Command codes on the input channel
    typedef enum logic [2:0] {
        MODE_IR8   = 3'd0,
        MODE_DR16  = 3'd1,
        MODE_DR20  = 3'd2,
        MODE_SET   = 3'd3,
        MODE_CLR   = 3'd4,
        MODE_RESET = 3'd5
    } t_mode;

    localparam int unsigned WORD_W = 20;
    localparam int unsigned CNT_W  = 5;

    // Data bit counts minus one
    localparam logic [CNT_W-1:0] NBITS_IR8_M1  = 5'd7;
    localparam logic [CNT_W-1:0] NBITS_DR16_M1 = 5'd15;
    localparam logic [CNT_W-1:0] NBITS_DR20_M1 = 5'd19;

    // Walk lengths minus one, reset sequence length minus one
    localparam logic [CNT_W-1:0] WALK_IR_M1  = 5'd3;
    localparam logic [CNT_W-1:0] WALK_DR_M1  = 5'd2;
    localparam logic [CNT_W-1:0] RESET_LEN_M1 = 5'd5;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DATA,
        ST_TCLK,
        ST_DONE,
        ST_SETCLK,
        ST_RESET
    } t_state;

    // TAP cycle kinds issued to the datapath
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WALK,
        OP_DATA,
        OP_TCLK,
        OP_DONE,
        OP_SETCLK,
        OP_RESET
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the command fields
        logic emit;      // produce one TAP cycle this clock
        t_op  op;
        logic cnt_zero;  // final cycle of the current phase
        logic walk_tms;  // TMS level during the walk phase
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             slot_free;  // output register can take a transfer
        logic [CNT_W-1:0] nbits_m1;   // shift length minus one of the held command
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hdl/tjss_ctrl.sv
// Sequencer controller: phase state machine and cycle counter.
// Depends on tjss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tjss_ctrl
    import tjss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [2:0] i_mode,
    output logic            o_ready,
    input  wire t_dp_sts    i_sts,
    output t_ctl_cmd        o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_adv;

    assign w_adv = (r_state != ST_IDLE) && i_sts.slot_free;

    // Next state and counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_mode)
                        MODE_IR8: begin
                            n_state = ST_WALK;
                            n_cnt   = WALK_IR_M1;
                        end
                        MODE_DR16, MODE_DR20: begin
                            n_state = ST_WALK;
                            n_cnt   = WALK_DR_M1;
                        end
                        MODE_SET, MODE_CLR: n_state = ST_SETCLK;
                        MODE_RESET: begin
                            n_state = ST_RESET;
                            n_cnt   = RESET_LEN_M1;
                        end
                        default: n_state = ST_IDLE;  // unused codes: dropped
                    endcase
                end
            end
            ST_WALK: begin
                if (w_adv) begin
                    if (r_cnt == '0) begin
                        n_state = ST_DATA;
                        n_cnt   = i_sts.nbits_m1;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ST_DATA: begin
                if (w_adv) begin
                    if (r_cnt == '0) n_state = ST_TCLK;
                    else             n_cnt   = r_cnt - 1'b1;
                end
            end
            ST_TCLK:   if (w_adv) n_state = ST_DONE;
            ST_DONE:   if (w_adv) n_state = ST_IDLE;
            ST_SETCLK: if (w_adv) n_state = ST_IDLE;
            ST_RESET: begin
                if (w_adv) begin
                    if (r_cnt == '0) n_state = ST_IDLE;
                    else             n_cnt   = r_cnt - 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_ready         = (r_state == ST_IDLE);
        o_cmd.load      = (r_state == ST_IDLE) && i_valid;
        o_cmd.emit      = w_adv;
        o_cmd.cnt_zero  = (r_cnt == '0);
        o_cmd.walk_tms  = (r_cnt[CNT_W-1:1] != '0);
        unique case (r_state)
            ST_WALK:   o_cmd.op = OP_WALK;
            ST_DATA:   o_cmd.op = OP_DATA;
            ST_TCLK:   o_cmd.op = OP_TCLK;
            ST_DONE:   o_cmd.op = OP_DONE;
            ST_SETCLK: o_cmd.op = OP_SETCLK;
            ST_RESET:  o_cmd.op = OP_RESET;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tjss_datapath.sv
// Sequencer datapath: command hold, shift register, pin levels, output register.
// Depends on tjss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tjss_datapath
    import tjss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl_cmd          i_cmd,
    input  wire logic [2:0]        i_mode,
    input  wire logic [WORD_W-1:0] i_shift_data,
    input  wire logic [WORD_W-1:0] i_target_tdo,
    input  wire logic              i_out_ready,
    output t_dp_sts                o_sts,
    output logic                   o_valid,
    output logic                   o_tms_out,
    output logic                   o_tdi_out,
    output logic                   o_cycle_kind,
    output logic                   o_data_cycle,
    output logic                   o_last,
    output logic [WORD_W-1:0]      o_captured
);

    // Held command
    t_mode             r_mode;
    logic [WORD_W-1:0] r_sh, n_sh;
    logic [WORD_W-1:0] r_tdo;

    // Pin levels
    logic r_tms_lvl, n_tms_lvl;
    logic r_tdi_lvl, n_tdi_lvl;
    logic r_tclk_lvl, n_tclk_lvl;

    // Output register
    logic              r_valid, n_valid;
    logic              r_tms, n_tms, r_tdi, n_tdi, r_kind, n_kind;
    logic              r_data, n_data, r_last, n_last;
    logic [WORD_W-1:0] r_cap, n_cap;

    logic              w_bit;
    logic              w_set;
    logic [WORD_W-1:0] w_cap;

    assign w_bit = r_sh[WORD_W-1];
    assign w_set = (r_mode == MODE_SET);

    // Status: slot free and shift length
    always_comb begin
        o_sts.slot_free = !r_valid || i_out_ready;
        unique case (r_mode)
            MODE_IR8:  o_sts.nbits_m1 = NBITS_IR8_M1;
            MODE_DR16: o_sts.nbits_m1 = NBITS_DR16_M1;
            default:   o_sts.nbits_m1 = NBITS_DR20_M1;
        endcase
    end

    // Capture word; the 20-bit result comes back rotated by four
    always_comb begin
        unique case (r_mode)
            MODE_IR8:  w_cap = {12'd0, r_tdo[7:0]};
            MODE_DR16: w_cap = {4'd0, r_tdo[15:0]};
            MODE_DR20: w_cap = {r_tdo[3:0], r_tdo[19:4]};
            default:   w_cap = '0;
        endcase
    end

    // One TAP cycle per emit
    always_comb begin
        n_sh       = r_sh;
        n_tms_lvl  = r_tms_lvl;
        n_tdi_lvl  = r_tdi_lvl;
        n_tclk_lvl = r_tclk_lvl;
        n_valid    = r_valid && !i_out_ready;
        n_tms      = r_tms;
        n_tdi      = r_tdi;
        n_kind     = r_kind;
        n_data     = r_data;
        n_last     = r_last;
        n_cap      = r_cap;

        // left-align the data so the MSB always leaves from the top
        if (i_cmd.load) begin
            unique case (t_mode'(i_mode))
                MODE_IR8:  n_sh = {i_shift_data[7:0], 12'd0};
                MODE_DR16: n_sh = {i_shift_data[15:0], 4'd0};
                default:   n_sh = i_shift_data;
            endcase
        end

        if (i_cmd.emit) begin
            n_valid = 1'b1;
            n_kind  = 1'b0;
            n_data  = 1'b0;
            n_last  = 1'b0;
            n_cap   = '0;
            n_tms   = r_tms_lvl;
            n_tdi   = r_tdi_lvl;
            unique case (i_cmd.op)
                OP_WALK: n_tms = i_cmd.walk_tms;
                OP_DATA: begin
                    n_tms     = i_cmd.cnt_zero;
                    n_tdi     = w_bit;
                    n_data    = 1'b1;
                    n_sh      = {r_sh[WORD_W-2:0], 1'b0};
                    n_tdi_lvl = w_bit;
                    n_tms_lvl = i_cmd.cnt_zero;
                end
                OP_TCLK: begin
                    n_tdi  = r_tclk_lvl;
                    n_kind = 1'b1;
                end
                OP_DONE: begin
                    n_tms     = 1'b0;
                    n_last    = 1'b1;
                    n_cap     = w_cap;
                    n_tms_lvl = 1'b0;
                end
                OP_SETCLK: begin
                    n_tdi      = w_set;
                    n_kind     = 1'b1;
                    n_last     = 1'b1;
                    n_tclk_lvl = w_set;
                end
                OP_RESET: begin
                    n_tms     = !i_cmd.cnt_zero;
                    n_tdi     = 1'b1;
                    n_last    = i_cmd.cnt_zero;
                    n_tdi_lvl = 1'b1;
                    if (i_cmd.cnt_zero) n_tms_lvl = 1'b1;
                end
                default: n_valid = r_valid && !i_out_ready;
            endcase
        end
    end

    // Control state and levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_tms_lvl  <= 1'b1;
            r_tdi_lvl  <= 1'b1;
            r_tclk_lvl <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_tms_lvl  <= n_tms_lvl;
            r_tdi_lvl  <= n_tdi_lvl;
            r_tclk_lvl <= n_tclk_lvl;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_tdo  <= i_target_tdo;
        end
        r_sh   <= n_sh;
        r_tms  <= n_tms;
        r_tdi  <= n_tdi;
        r_kind <= n_kind;
        r_data <= n_data;
        r_last <= n_last;
        r_cap  <= n_cap;
    end

    assign o_valid      = r_valid;
    assign o_tms_out    = r_tms;
    assign o_tdi_out    = r_tdi;
    assign o_cycle_kind = r_kind;
    assign o_data_cycle = r_data;
    assign o_last       = r_last;
    assign o_captured   = r_cap;

endmodule

`default_nettype wire

FILE: hdl/two_wire_jtag_shift_sequencer.sv
// Two-wire JTAG shift sequencer, top level.
// Usage: one command per input transfer (i_valid/o_ready: mode, shift data and
// the TDO bits the target answers with). Each command yields a run of output
// transfers (o_valid/i_ready), one per TAP cycle, giving the TMS and TDI slot
// levels, the cycle kind and data flag; o_last marks the final TAP cycle,
// which for an IR or DR shift carries the captured word.
// Lengths in output transfers: IR shift 14, DR shift 21 or 25, set/clear TCLK 1,
// TAP reset 6; unused mode codes are taken and give nothing.
// Order: a command moves the controller out of idle, then its first TAP cycle
// is held in the output register. Throughput: one TAP cycle per clock into a
// single output register, while that register is free; a new command is taken
// only once the controller is back in its idle state.
// Reset: levels return to TMS 1, TDI 1, TCLK 0, any pending result is dropped.
// Stall: while i_ready is low the output register holds and the sequencer
// waits; nothing is lost or repeated.
// Depends on tjss_pkg, tjss_ctrl, tjss_datapath and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "two_wire_jtag_shift_sequencer_macros.svh"

module two_wire_jtag_shift_sequencer
    import tjss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2:0]        i_mode,
    input  wire logic [WORD_W-1:0] i_shift_data,
    input  wire logic [WORD_W-1:0] i_target_tdo,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_tms_out,
    output logic                   o_tdi_out,
    output logic                   o_cycle_kind,
    output logic                   o_data_cycle,
    output logic                   o_last,
    output logic [WORD_W-1:0]      o_captured
);

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    tjss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tjss_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_mode       (i_mode),
        .i_shift_data (i_shift_data),
        .i_target_tdo (i_target_tdo),
        .i_out_ready  (i_ready),
        .o_sts        (w_sts),
        .o_valid      (o_valid),
        .o_tms_out    (o_tms_out),
        .o_tdi_out    (o_tdi_out),
        .o_cycle_kind (o_cycle_kind),
        .o_data_cycle (o_data_cycle),
        .o_last       (o_last),
        .o_captured   (o_captured)
    );

    // Checks
    `TJSS_ASSERT_IMPL(a_no_emit_when_idle, o_ready, !w_cmd.emit)
    `TJSS_ASSERT_IMPL(a_no_overwrite, w_cmd.emit, !o_valid || i_ready)
    `TJSS_ASSERT_IMPL(a_cap_only_last, o_valid && !o_last, o_captured == '0)
    `TJSS_ASSERT_IMPL(a_data_not_tclk, o_valid && o_data_cycle, !o_cycle_kind)

endmodule

`default_nettype wire
